/* design/gqi_pkg.sv */
`timescale 1ns / 1ps
// Package for the grid quadrilinear interpolator.
// Holds the mode codes, register indexes and fixed widths. It has no dependencies.
package gqi_pkg;

    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 19;
    localparam int CELL_W   = 8;
    localparam int FRAC_W   = 16;
    localparam int PADDR_W  = 5;
    localparam int NUM_AXES = 4;

    localparam logic [1:0] MODE_TRI  = 2'd0;
    localparam logic [1:0] MODE_QUAD = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;

    localparam logic [2:0] REG_X_ORIGIN  = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN  = 3'd1;
    localparam logic [2:0] REG_Z_ORIGIN  = 3'd2;
    localparam logic [2:0] REG_X_SCALE   = 3'd3;
    localparam logic [2:0] REG_Y_SCALE   = 3'd4;
    localparam logic [2:0] REG_Z_SCALE   = 3'd5;
    localparam logic [2:0] REG_E_ORIGIN  = 3'd6;
    localparam logic [2:0] REG_E_SCALE   = 3'd7;

    localparam logic [DATA_W-1:0] SCALE_RESET = 32'd65536;

endpackage

/* design/gqi_if.sv */
`timescale 1ns / 1ps
// Handshake interfaces for query and result transfers.
// Depends on nothing but the fixed field widths listed here.
interface gqi_query_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [3:0]         energy_slot;
    logic signed [31:0] log_energy;
    logic [18:0]        load_address;
    logic signed [31:0] load_value;

    modport source (output valid, mode, pos_x, pos_y, pos_z, energy_slot, log_energy,
                    load_address, load_value, input ready);
    modport sink (input valid, mode, pos_x, pos_y, pos_z, energy_slot, log_energy,
                  load_address, load_value, output ready);
endinterface

interface gqi_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] flux;
    logic               outside;

    modport source (output valid, flux, outside, input ready);
    modport sink (input valid, flux, outside, output ready);
endinterface

/* design/gqi_lerp.sv */
`timescale 1ns / 1ps
// Linear blend of two Q16.16 words by a Q0.16 weight, rounded toward minus infinity.
// Depends on gqi_pkg.
module gqi_lerp
    import gqi_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic [FRAC_W-1:0]        f,
    output logic signed [DATA_W-1:0] y
);
    logic signed [DATA_W:0]          diff;
    logic signed [DATA_W+FRAC_W+1:0] prod;
    logic signed [DATA_W+FRAC_W+2:0] sum;

    assign diff = {b[DATA_W-1], b} - {a[DATA_W-1], a};
    assign prod = diff * $signed({1'b0, f});
    assign sum  = {{3{a[DATA_W-1]}}, a, {FRAC_W{1'b0}}} + {prod[DATA_W+FRAC_W+1], prod};
    assign y    = sum[DATA_W+FRAC_W-1:FRAC_W];
endmodule

/* design/grid_quadrilinear_interpolator.sv */
`timescale 1ns / 1ps
// Interpolator over a 4D flux table held in one single-port memory of 2^19 words.
// A load writes one table word. A query subtracts the origin, scales and checks
// each axis, forms the base address, then reads and blends 8 corners when
// trilinear or 16 corners when quadrilinear. Corners come one at a time from the
// one table read port and go through the single shared blend unit. One query is
// worked at a time; a finished result waits in the output register. Depends on
// gqi_pkg, gqi_if and gqi_lerp.
module grid_quadrilinear_interpolator
    import gqi_pkg::*;
#(
    parameter int NX = 32,
    parameter int NY = 32,
    parameter int NZ = 32,
    parameter int NE = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    gqi_query_if.sink           query,
    gqi_result_if.source        result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);
    localparam int DEPTH = 1 << ADDR_W;
    localparam logic [ADDR_W-1:0] OFF_Z = ADDR_W'(NE);
    localparam logic [ADDR_W-1:0] OFF_Y = ADDR_W'(NZ * NE);
    localparam logic [ADDR_W-1:0] OFF_X = ADDR_W'(NY * NZ * NE);

    typedef enum logic [3:0] {
        S_IDLE, S_SUB, S_MUL, S_CHK, S_BASE, S_READ, S_WAIT, S_COMB, S_DONE
    } state_t;

    logic [DATA_W-1:0] cfg_reg [8];

    state_t                    state_reg;
    logic [1:0]                mode_reg;
    logic [DATA_W-1:0]         coord_reg [NUM_AXES];
    logic [3:0]                slot_reg;
    logic [ADDR_W-1:0]         ld_addr_reg;
    logic [DATA_W-1:0]         ld_val_reg;
    logic [DATA_W-1:0]         dmag_reg [NUM_AXES];
    logic                      dpos_reg [NUM_AXES];
    logic [2*DATA_W-1:0]       prod_reg [NUM_AXES];
    logic [CELL_W-1:0]         cell_reg [NUM_AXES];
    logic [FRAC_W-1:0]         frac_reg [NUM_AXES];
    logic [ADDR_W-1:0]         base_reg;
    logic [3:0]                k_reg;
    logic [2:0]                lv_reg;
    logic signed [DATA_W-1:0]  cv_reg;
    logic signed [DATA_W-1:0]  hold_reg [4];
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_flux_reg;
    logic                      out_outside_reg;
    logic signed [DATA_W-1:0]  res_flux_reg;
    logic                      res_outside_reg;

    logic [DATA_W-1:0]         rd_data_reg;
    logic [DATA_W-1:0]         mem [DEPTH];

    logic [DATA_W-1:0]         origin [NUM_AXES];
    logic [DATA_W-1:0]         scale [NUM_AXES];
    logic [DATA_W-1:0]         lim [NUM_AXES];
    logic [DATA_W:0]           diff [NUM_AXES];
    logic                      ok [NUM_AXES];
    logic [ADDR_W-1:0]         offset;
    logic [ADDR_W-1:0]         mem_addr;
    logic                      mem_we;
    logic [FRAC_W-1:0]         lv_frac;
    logic signed [DATA_W-1:0]  blend;
    logic [2:0]                top_lv;
    logic                      slot_ok;
    logic                      all_ok;
    logic                      out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_X_ORIGIN] <= '0;
            cfg_reg[REG_Y_ORIGIN] <= '0;
            cfg_reg[REG_Z_ORIGIN] <= '0;
            cfg_reg[REG_X_SCALE]  <= SCALE_RESET;
            cfg_reg[REG_Y_SCALE]  <= SCALE_RESET;
            cfg_reg[REG_Z_SCALE]  <= SCALE_RESET;
            cfg_reg[REG_E_ORIGIN] <= '0;
            cfg_reg[REG_E_SCALE]  <= SCALE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            cfg_reg[paddr[4:2]] <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = cfg_reg[paddr[4:2]];

    always_comb
    begin
        origin[0] = cfg_reg[REG_X_ORIGIN];
        origin[1] = cfg_reg[REG_Y_ORIGIN];
        origin[2] = cfg_reg[REG_Z_ORIGIN];
        origin[3] = cfg_reg[REG_E_ORIGIN];
        scale[0]  = cfg_reg[REG_X_SCALE];
        scale[1]  = cfg_reg[REG_Y_SCALE];
        scale[2]  = cfg_reg[REG_Z_SCALE];
        scale[3]  = cfg_reg[REG_E_SCALE];
        lim[0]    = DATA_W'(NX - 1);
        lim[1]    = DATA_W'(NY - 1);
        lim[2]    = DATA_W'(NZ - 1);
        lim[3]    = DATA_W'(NE - 1);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            diff[i] = {coord_reg[i][DATA_W-1], coord_reg[i]}
                    - {origin[i][DATA_W-1], origin[i]};
            ok[i]   = dpos_reg[i] && (prod_reg[i] != '0)
                    && (prod_reg[i][2*DATA_W-1:DATA_W] < lim[i]);
        end
        slot_ok = ({5'd0, slot_reg} < 9'(NE));
        all_ok  = ok[0] && ok[1] && ok[2] && ((mode_reg == MODE_QUAD) ? ok[3] : slot_ok);
        top_lv  = (mode_reg == MODE_QUAD) ? 3'd4 : 3'd3;
    end

    always_comb
    begin
        offset = (k_reg[0] ? OFF_Z : '0) + (k_reg[1] ? OFF_Y : '0)
               + (k_reg[2] ? OFF_X : '0) + (k_reg[3] ? ADDR_W'(1) : '0);
        mem_we   = (state_reg == S_SUB) && (mode_reg == MODE_LOAD);
        mem_addr = mem_we ? ld_addr_reg : base_reg + offset;
        case (lv_reg)
            3'd0:    lv_frac = frac_reg[2];
            3'd1:    lv_frac = frac_reg[1];
            3'd2:    lv_frac = frac_reg[0];
            default: lv_frac = frac_reg[3];
        endcase
        out_free = !out_valid_reg || result.ready;
    end

    gqi_lerp u_lerp (
        .a (hold_reg[lv_reg[1:0]]),
        .b (cv_reg),
        .f (lv_frac),
        .y (blend)
    );

    // Flux table.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= ld_val_reg;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_TRI;
            k_reg           <= '0;
            lv_reg          <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (query.valid)
                    begin
                        mode_reg     <= query.mode;
                        coord_reg[0] <= query.pos_x;
                        coord_reg[1] <= query.pos_y;
                        coord_reg[2] <= query.pos_z;
                        coord_reg[3] <= query.log_energy;
                        slot_reg     <= query.energy_slot;
                        ld_addr_reg  <= query.load_address;
                        ld_val_reg   <= query.load_value;
                        state_reg    <= S_SUB;
                    end
                end
                S_SUB:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        dmag_reg[i] <= diff[i][DATA_W-1:0];
                        dpos_reg[i] <= !diff[i][DATA_W] && (diff[i] != '0);
                    end
                    res_flux_reg    <= '0;
                    res_outside_reg <= 1'b0;
                    if (mode_reg == MODE_TRI || mode_reg == MODE_QUAD)
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_MUL:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        prod_reg[i] <= dmag_reg[i] * scale[i];
                    end
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    for (int i = 0; i < NUM_AXES - 1; i++)
                    begin
                        cell_reg[i] <= prod_reg[i][DATA_W+CELL_W-1:DATA_W];
                        frac_reg[i] <= prod_reg[i][DATA_W-1:DATA_W-FRAC_W];
                    end
                    frac_reg[NUM_AXES-1] <= prod_reg[NUM_AXES-1][DATA_W-1:DATA_W-FRAC_W];
                    cell_reg[NUM_AXES-1] <= (mode_reg == MODE_TRI) ? CELL_W'(slot_reg)
                                          : prod_reg[NUM_AXES-1][DATA_W+CELL_W-1:DATA_W];
                    if (all_ok)
                    begin
                        state_reg <= S_BASE;
                    end
                    else
                    begin
                        res_outside_reg <= 1'b1;
                        state_reg       <= S_DONE;
                    end
                end
                S_BASE:
                begin
                    base_reg  <= ADDR_W'((((ADDR_W'(cell_reg[0]) * ADDR_W'(NY)
                                 + ADDR_W'(cell_reg[1])) * ADDR_W'(NZ)
                                 + ADDR_W'(cell_reg[2])) * ADDR_W'(NE))
                                 + ADDR_W'(cell_reg[3]));
                    k_reg     <= '0;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    cv_reg    <= rd_data_reg;
                    lv_reg    <= '0;
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    if (lv_reg == top_lv)
                    begin
                        res_flux_reg <= cv_reg;
                        state_reg    <= S_DONE;
                    end
                    else if (k_reg[lv_reg[1:0]])
                    begin
                        cv_reg <= blend;
                        lv_reg <= lv_reg + 3'd1;
                    end
                    else
                    begin
                        hold_reg[lv_reg[1:0]] <= cv_reg;
                        k_reg                 <= k_reg + 4'd1;
                        state_reg             <= S_READ;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_flux_reg    <= res_flux_reg;
                        out_outside_reg <= res_outside_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign query.ready    = (state_reg == S_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.flux    = out_flux_reg;
    assign result.outside = out_outside_reg;
endmodule

/* design/gqi_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the grid quadrilinear interpolator, bound to the top level.
// Depends on the top level's port names only.
module gqi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_flux,
    input logic        out_outside
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_flux) && $stable(out_outside))
        else $error("result payload changed while stalled");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_outside |-> out_flux == 32'd0)
        else $error("outside result carries nonzero flux");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("query taken while previous query still in work");
endmodule

bind grid_quadrilinear_interpolator gqi_checker u_gqi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (query.valid),
    .in_ready    (query.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_flux    (result.flux),
    .out_outside (result.outside)
);
